// ----- design/wegu_pkg.sv -----
package wegu_pkg;

    localparam int COORD_W = 5;
    localparam int ENTRY_W = 10;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = 1;
    localparam int CFG_AW = 5;

    localparam logic KIND_APPLY = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [2:0] DIR_UP = 3'd0;
    localparam logic [2:0] DIR_DOWN = 3'd1;
    localparam logic [2:0] DIR_LEFT = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;

    localparam logic [1:0] CLS_WALL = 2'd0;
    localparam logic [1:0] CLS_OPEN = 2'd1;
    localparam logic [1:0] CLS_AMBIG = 2'd2;
    localparam logic [1:0] CLS_POST = 2'd3;

    localparam logic [1:0] FIT_NONE = 2'd0;
    localparam logic [1:0] FIT_FACE = 2'd1;
    localparam logic [1:0] FIT_POST = 2'd2;
    localparam logic [1:0] FIT_OTHER = 2'd3;

    localparam logic [1:0] EDGE_UNKNOWN = 2'd0;
    localparam logic [1:0] EDGE_WALL = 2'd1;
    localparam logic [1:0] EDGE_OPEN = 2'd2;

    localparam logic [2:0] REG_MIN_CONF = 3'd0;
    localparam logic [2:0] REG_WALL_W = 3'd1;
    localparam logic [2:0] REG_OPEN_W = 3'd2;
    localparam logic [2:0] REG_MAX_SCORE = 3'd3;
    localparam logic [2:0] REG_WALL_THR = 3'd4;
    localparam logic [2:0] REG_OPEN_THR = 3'd5;

    typedef struct packed {
        logic [7:0] min_conf;
        logic [6:0] wall_w;
        logic [6:0] open_w;
        logic [6:0] max_score;
        logic [7:0] wall_thr;
        logic [7:0] open_thr;
    } t_cfg;

    typedef struct packed {
        logic               query;
        logic               hit;
        logic               write;
        logic               vert;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [7:0]         delta;
    } t_op;

endpackage

// ----- design/wegu_front.sv -----
module wegu_front
    import wegu_pkg::*;
#(
    parameter int MAZE_SIZE = 16
) (
    input  logic        i_tvalid,
    output logic        o_tready,
    // tdata: cell_x, cell_y, direction, obs_valid, obs_confidence, obs_class,
    // fit_type, fit_x, fit_y, fit_direction, freeze
    input  logic [39:0] i_tdata,
    // tuser: kind
    input  logic [0:0]  i_tuser,
    input  t_cfg        i_cfg,
    input  logic        i_q_full,
    input  logic        i_clr_busy,
    output logic        o_push,
    output t_op         o_op
);

    logic [3:0] x, y, fx, fy, tx, ty;
    logic [2:0] dir, fd, td;
    logic       vld, frz, kind, reject, exists;
    logic [7:0] conf;
    logic [1:0] cls, ft;

    assign o_tready = !i_q_full && !i_clr_busy;
    assign o_push = i_tvalid && o_tready;

    always_comb begin
        x = i_tdata[3:0];
        y = i_tdata[7:4];
        dir = i_tdata[10:8];
        vld = i_tdata[11];
        conf = i_tdata[19:12];
        cls = i_tdata[21:20];
        ft = i_tdata[23:22];
        fx = i_tdata[27:24];
        fy = i_tdata[31:28];
        fd = i_tdata[34:32];
        frz = i_tdata[35];
        kind = i_tuser[0];

        reject = frz || !vld || (conf < i_cfg.min_conf) || (dir > DIR_RIGHT)
              || (cls == CLS_AMBIG) || (cls == CLS_POST)
              || (cls == CLS_OPEN && ft == FIT_POST);

        tx = x;
        ty = y;
        td = dir;
        if (kind == KIND_QUERY) begin
            if (dir > DIR_RIGHT) begin
                td = DIR_RIGHT;
            end
        end else if (ft == FIT_FACE && fd <= DIR_RIGHT) begin
            tx = fx;
            ty = fy;
            td = fd;
        end

        exists = (32'(tx) < 32'(MAZE_SIZE)) && (32'(ty) < 32'(MAZE_SIZE));

        o_op.query = (kind == KIND_QUERY);
        o_op.hit = exists && ((kind == KIND_QUERY) || !reject);
        o_op.write = o_op.hit && (kind == KIND_APPLY);
        o_op.vert = (td == DIR_LEFT) || (td == DIR_RIGHT);
        o_op.col = COORD_W'({1'b0, tx}) + COORD_W'(td == DIR_RIGHT);
        o_op.row = COORD_W'({1'b0, ty}) + COORD_W'(td == DIR_UP);
        o_op.delta = (cls == CLS_WALL) ? {1'b0, i_cfg.wall_w}
                                       : 8'd0 - {1'b0, i_cfg.open_w};
    end

endmodule

// ----- design/wegu_queue.sv -----
module wegu_queue
    import wegu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_op  o_op
);

    t_op                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- design/wegu_back.sv -----
module wegu_back
    import wegu_pkg::*;
#(
    parameter int MAZE_SIZE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_op         i_op,
    output logic        o_pop,
    output logic        o_clr_busy,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [15:0] o_tdata
);

    localparam int DEPTH = MAZE_SIZE * (MAZE_SIZE + 1);
    localparam int AW = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;

    logic [ENTRY_W-1:0] r_h_mem [DEPTH];
    logic [ENTRY_W-1:0] r_v_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rd_h, r_rd_v;

    logic [1:0]   r_state, n_state;
    t_op          r_op;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_clr_addr;
    logic          r_clr_busy;
    logic          r_out_valid;
    logic [15:0]   r_out_data, n_out_data;

    logic [31:0]        addr_full;
    logic               calc_fire;
    logic [ENTRY_W-1:0] cur_entry, new_entry;
    logic signed [8:0]  sum, lim, neg_lim, s9, wt9, ot_neg;
    logic [1:0]         new_class;
    logic               we_h, we_v;
    logic [AW-1:0]      wa;
    logic [ENTRY_W-1:0] wd;

    assign o_clr_busy = r_clr_busy;
    assign o_tvalid = r_out_valid;
    assign o_tdata = r_out_data;
    assign o_pop = (r_state == S_IDLE) && i_q_valid && !r_clr_busy;
    assign calc_fire = (r_state == S_CALC) && (!r_out_valid || i_tready);

    always_comb begin
        addr_full = 32'(i_op.col) * 32'(MAZE_SIZE) + 32'(i_op.row)
                  + (i_op.vert ? 32'd0 : 32'(i_op.col));
    end

    always_comb begin
        cur_entry = r_op.vert ? r_rd_v : r_rd_h;
        sum = $signed({cur_entry[7], cur_entry[7:0]})
            + $signed({r_op.delta[7], r_op.delta});
        lim = $signed({2'b00, i_cfg.max_score});
        neg_lim = 9'sd0 - lim;
        if (sum > lim) begin
            s9 = lim;
        end else if (sum < neg_lim) begin
            s9 = neg_lim;
        end else begin
            s9 = sum;
        end
        wt9 = $signed({i_cfg.wall_thr[7], i_cfg.wall_thr});
        ot_neg = 9'sd0 - $signed({i_cfg.open_thr[7], i_cfg.open_thr});
        if (s9 >= wt9) begin
            new_class = EDGE_WALL;
        end else if (s9 <= ot_neg) begin
            new_class = EDGE_OPEN;
        end else begin
            new_class = EDGE_UNKNOWN;
        end
        new_entry = {new_class, s9[7:0]};

        n_out_data = '0;
        if (r_op.hit) begin
            if (r_op.query) begin
                n_out_data[10:1] = {cur_entry[9:8], cur_entry[7:0]};
            end else begin
                n_out_data[10:0] = {new_entry, 1'b1};
            end
        end
    end

    always_comb begin
        we_h = r_clr_busy || (calc_fire && r_op.write && !r_op.vert);
        we_v = r_clr_busy || (calc_fire && r_op.write && r_op.vert);
        wa = r_clr_busy ? r_clr_addr : r_addr;
        wd = r_clr_busy ? '0 : new_entry;
    end

    always_ff @(posedge i_clk) begin
        if (we_h) begin
            r_h_mem[wa] <= wd;
        end
        if (we_v) begin
            r_v_mem[wa] <= wd;
        end
        if (r_state == S_READ) begin
            r_rd_h <= r_h_mem[r_addr];
            r_rd_v <= r_v_mem[r_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                if (calc_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_op;
            r_addr <= addr_full[AW-1:0];
        end
        if (calc_fire) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (calc_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- design/wall_evidence_grid_update_unit.sv -----
// An item passes the front classifier into a two-word queue and then the back end's three
// states: pop, store read, then score update and write, which registers its result word.
// The back end carries one item at a time through these states and pops no new item until
// the current one leaves the update state, which waits while the output word is not taken.
// Reset loads the register defaults and starts a pass that zeroes all MAZE_SIZE*(MAZE_SIZE+1)
// entries of both edge stores (272 by default), with s_axis_tready low.
module wall_evidence_grid_update_unit
    import wegu_pkg::*;
#(
    parameter int MAZE_SIZE = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // tdata: cell_x, cell_y, direction, obs_valid, obs_confidence, obs_class,
    // fit_type, fit_x, fit_y, fit_direction, freeze
    input  logic [39:0]        s_axis_tdata,
    // tuser: kind
    input  logic [0:0]         s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // tdata: applied, edge_score, edge_state
    output logic [15:0]        m_axis_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [CFG_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg r_cfg;
    logic q_full, q_valid, push, pop, clr_busy;
    t_op  push_op, head_op;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_conf <= 8'd128;
            r_cfg.wall_w <= 7'd2;
            r_cfg.open_w <= 7'd1;
            r_cfg.max_score <= 7'd10;
            r_cfg.wall_thr <= 8'd4;
            r_cfg.open_thr <= 8'd4;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[4:2])
                REG_MIN_CONF: r_cfg.min_conf <= pwdata[7:0];
                REG_WALL_W: r_cfg.wall_w <= pwdata[6:0];
                REG_OPEN_W: r_cfg.open_w <= pwdata[6:0];
                REG_MAX_SCORE: r_cfg.max_score <= pwdata[6:0];
                REG_WALL_THR: r_cfg.wall_thr <= pwdata[7:0];
                REG_OPEN_THR: r_cfg.open_thr <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[4:2])
            REG_MIN_CONF: prdata[7:0] = r_cfg.min_conf;
            REG_WALL_W: prdata[6:0] = r_cfg.wall_w;
            REG_OPEN_W: prdata[6:0] = r_cfg.open_w;
            REG_MAX_SCORE: prdata[6:0] = r_cfg.max_score;
            REG_WALL_THR: prdata[7:0] = r_cfg.wall_thr;
            REG_OPEN_THR: prdata[7:0] = r_cfg.open_thr;
            default: prdata = '0;
        endcase
    end

    wegu_front #(
        .MAZE_SIZE(MAZE_SIZE)
    ) u_front (
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_tdata   (s_axis_tdata),
        .i_tuser   (s_axis_tuser),
        .i_cfg     (r_cfg),
        .i_q_full  (q_full),
        .i_clr_busy(clr_busy),
        .o_push    (push),
        .o_op      (push_op)
    );

    wegu_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_op   (push_op),
        .o_full (q_full),
        .o_valid(q_valid),
        .i_pop  (pop),
        .o_op   (head_op)
    );

    wegu_back #(
        .MAZE_SIZE(MAZE_SIZE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_op      (head_op),
        .o_pop     (pop),
        .o_clr_busy(clr_busy),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata)
    );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb
    import wegu_pkg::*;
();

    localparam int GRID = 16;
    localparam int EDGES = GRID * (GRID + 1);

    typedef struct {
        logic       kind;
        logic [3:0] cx;
        logic [3:0] cy;
        logic [2:0] dir;
        logic       valid;
        logic [7:0] conf;
        logic [1:0] cls;
        logic [1:0] ftype;
        logic [3:0] fx;
        logic [3:0] fy;
        logic [2:0] fdir;
        logic       freeze;
    } t_obs;

    typedef struct {
        logic              applied;
        logic signed [7:0] score;
        logic [1:0]        state;
    } t_edge_res;

    typedef struct {
        t_obs      it;
        bit        fixed;
        t_edge_res want;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata;
    logic [0:0]        s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [15:0]       m_axis_tdata;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    wall_evidence_grid_update_unit #(.MAZE_SIZE(GRID)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    logic signed [7:0] horiz_score [0:EDGES-1];
    logic [1:0]        horiz_state [0:EDGES-1];
    logic signed [7:0] vert_score [0:EDGES-1];
    logic [1:0]        vert_state [0:EDGES-1];

    logic [7:0]        min_conf;
    logic [6:0]        wall_w;
    logic [6:0]        open_w;
    logic [6:0]        max_score;
    logic signed [7:0] wall_thr;
    logic signed [7:0] open_thr;

    t_edge_res pending_edges [$];
    t_row      directed_rows [$];
    int        errors;
    int        burst_left;
    bit        no_gaps;
    int        rx_mode;
    int        rx_stall;
    int        rx_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch in %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
        errors++;
    endtask

    function automatic t_obs obs(logic kind, logic [3:0] cx, logic [3:0] cy, logic [2:0] dir,
                                 logic valid, logic [7:0] conf, logic [1:0] cls,
                                 logic [1:0] ftype, logic [3:0] fx, logic [3:0] fy,
                                 logic [2:0] fdir, logic freeze);
        t_obs o;
        o.kind = kind;
        o.cx = cx;
        o.cy = cy;
        o.dir = dir;
        o.valid = valid;
        o.conf = conf;
        o.cls = cls;
        o.ftype = ftype;
        o.fx = fx;
        o.fy = fy;
        o.fdir = fdir;
        o.freeze = freeze;
        return o;
    endfunction

    function automatic t_edge_res res(logic a, logic signed [7:0] s, logic [1:0] st);
        t_edge_res r;
        r.applied = a;
        r.score = s;
        r.state = st;
        return r;
    endfunction

    function automatic logic [39:0] pack_obs(t_obs o);
        return {4'b0, o.freeze, o.fdir, o.fy, o.fx, o.ftype, o.cls, o.conf, o.valid,
                o.dir, o.cy, o.cx};
    endfunction

    function automatic int edge_index(logic [3:0] x, logic [3:0] y, logic [2:0] d);
        if (d == DIR_UP || d == DIR_DOWN) begin
            return int'(x) * (GRID + 1) + int'(y) + ((d == DIR_UP) ? 1 : 0);
        end
        return (int'(x) + ((d == DIR_LEFT) ? 0 : 1)) * GRID + int'(y);
    endfunction

    function automatic t_edge_res predict_edge(t_obs o);
        t_edge_res r;
        logic [3:0] x;
        logic [3:0] y;
        logic [2:0] d;
        bit         vert;
        int         idx;
        int         cur;
        int         nxt;
        int         lim;
        logic [1:0] st;
        r = res(1'b0, 8'sd0, EDGE_UNKNOWN);
        x = o.cx;
        y = o.cy;
        d = o.dir;
        if (o.kind == KIND_QUERY) begin
            if (d > DIR_RIGHT) begin
                d = DIR_RIGHT;
            end
            idx = edge_index(x, y, d);
            if (d == DIR_UP || d == DIR_DOWN) begin
                r = res(1'b0, horiz_score[idx], horiz_state[idx]);
            end else begin
                r = res(1'b0, vert_score[idx], vert_state[idx]);
            end
            return r;
        end
        if (o.freeze || !o.valid || o.conf < min_conf || d > DIR_RIGHT) return r;
        if (o.cls == CLS_AMBIG || o.cls == CLS_POST) return r;
        if (o.cls == CLS_OPEN && o.ftype == FIT_POST) return r;
        if (o.ftype == FIT_FACE && o.fdir <= DIR_RIGHT) begin
            x = o.fx;
            y = o.fy;
            d = o.fdir;
        end
        vert = !(d == DIR_UP || d == DIR_DOWN);
        idx = edge_index(x, y, d);
        cur = vert ? int'(vert_score[idx]) : int'(horiz_score[idx]);
        lim = int'(max_score);
        nxt = cur + ((o.cls == CLS_WALL) ? int'(wall_w) : -int'(open_w));
        if (nxt > lim) begin
            nxt = lim;
        end else if (nxt < -lim) begin
            nxt = -lim;
        end
        if (nxt >= int'(wall_thr)) begin
            st = EDGE_WALL;
        end else if (nxt <= -int'(open_thr)) begin
            st = EDGE_OPEN;
        end else begin
            st = EDGE_UNKNOWN;
        end
        if (vert) begin
            vert_score[idx] = nxt[7:0];
            vert_state[idx] = st;
        end else begin
            horiz_score[idx] = nxt[7:0];
            horiz_state[idx] = st;
        end
        return res(1'b1, nxt[7:0], st);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MIN_CONF:  min_conf = value[7:0];
            REG_WALL_W:    wall_w = value[6:0];
            REG_OPEN_W:    open_w = value[6:0];
            REG_MAX_SCORE: max_score = value[6:0];
            REG_WALL_THR:  wall_thr = value[7:0];
            REG_OPEN_THR:  open_thr = value[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(int mc, int ww, int ow, int ms, int wt, int ot);
        write_reg(REG_MIN_CONF, mc);
        write_reg(REG_WALL_W, ww);
        write_reg(REG_OPEN_W, ow);
        write_reg(REG_MAX_SCORE, ms);
        write_reg(REG_WALL_THR, wt);
        write_reg(REG_OPEN_THR, ot);
    endtask

    task automatic send_word(t_obs o, bit fixed, t_edge_res want);
        int gap;
        t_edge_res got;
        if (burst_left == 0) begin
            gap = (no_gaps || $urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pack_obs(o);
        s_axis_tuser <= o.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        got = predict_edge(o);
        if (fixed) begin
            pending_edges.push_back(want);
        end else begin
            pending_edges.push_back(got);
        end
        burst_left--;
    endtask

    task automatic stop_and_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [3:0] pick_coord();
        return ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 2)) : 4'($urandom_range(0, 15));
    endfunction

    function automatic t_obs random_obs();
        t_obs o;
        int   pick;
        o = obs(1'($urandom), 4'($urandom), 4'($urandom), 3'($urandom), 1'($urandom),
                8'($urandom), 2'($urandom), 2'($urandom), 4'($urandom), 4'($urandom),
                3'($urandom), 1'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            o.kind = KIND_QUERY;
            o.cx = pick_coord();
            o.cy = pick_coord();
        end else if (pick < 85) begin
            o.kind = KIND_APPLY;
            o.cx = pick_coord();
            o.cy = pick_coord();
            o.dir = 3'($urandom_range(0, 3));
            o.valid = 1'b1;
            o.freeze = 1'b0;
            o.conf = 8'($urandom_range(255, int'(min_conf)));
            o.cls = ($urandom_range(0, 9) < 6) ? CLS_WALL : CLS_OPEN;
            o.fx = pick_coord();
            o.fy = pick_coord();
            o.fdir = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 3))
                                                 : 3'($urandom_range(4, 7));
        end
        return o;
    endfunction

    always @(negedge i_clk) begin
        rx_cycles++;
        if (rx_cycles % 150 == 0) begin
            rx_mode = $urandom_range(0, 2);
        end
        if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else if (rx_mode == 1) begin
            m_axis_tready <= 1'($urandom_range(0, 1));
        end else if (rx_mode == 2 && $urandom_range(0, 7) == 0) begin
            rx_stall = $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_edge_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_edges.size() == 0) begin
                report_mismatch("word with nothing pending", int'(m_axis_tdata), 0);
            end else begin
                want = pending_edges.pop_front();
                if (m_axis_tdata[0] !== want.applied) begin
                    report_mismatch("applied", int'(m_axis_tdata[0]), int'(want.applied));
                end
                if (m_axis_tdata[8:1] !== want.score) begin
                    report_mismatch("edge_score", int'($signed(m_axis_tdata[8:1])),
                                    int'(want.score));
                end
                if (m_axis_tdata[10:9] !== want.state) begin
                    report_mismatch("edge_state", int'(m_axis_tdata[10:9]), int'(want.state));
                end
            end
        end
    end

    task automatic add_row(t_obs o, bit fixed, t_edge_res want);
        t_row rw;
        rw.it = o;
        rw.fixed = fixed;
        rw.want = want;
        directed_rows.push_back(rw);
    endtask

    initial begin
        t_edge_res zero;
        t_edge_res dummy;
        int        n;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        burst_left = 0;
        no_gaps = 1'b0;
        rx_mode = 0;
        rx_stall = 0;
        rx_cycles = 0;
        for (int i = 0; i < EDGES; i++) begin
            horiz_score[i] = '0;
            horiz_state[i] = EDGE_UNKNOWN;
            vert_score[i] = '0;
            vert_state[i] = EDGE_UNKNOWN;
        end
        min_conf = 8'd128;
        wall_w = 7'd2;
        open_w = 7'd1;
        max_score = 7'd10;
        wall_thr = 8'sd4;
        open_thr = 8'sd4;
        zero = res(1'b0, 8'sd0, EDGE_UNKNOWN);
        dummy = zero;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);

        add_row(obs(KIND_QUERY, 0, 0, DIR_UP, 0, 0, CLS_WALL, FIT_NONE, 0, 0, 0, 0), 1, zero);
        add_row(obs(KIND_QUERY, 15, 15, 7, 1, 255, CLS_POST, FIT_OTHER, 15, 15, 7, 1), 1, zero);
        add_row(obs(KIND_APPLY, 1, 1, DIR_UP, 1, 200, CLS_WALL, FIT_NONE, 0, 0, 0, 1), 1, zero);
        add_row(obs(KIND_APPLY, 1, 1, DIR_UP, 0, 200, CLS_WALL, FIT_NONE, 0, 0, 0, 0), 1, zero);
        add_row(obs(KIND_APPLY, 1, 1, DIR_UP, 1, 127, CLS_WALL, FIT_NONE, 0, 0, 0, 0), 1, zero);
        add_row(obs(KIND_APPLY, 1, 1, 4, 1, 200, CLS_WALL, FIT_NONE, 0, 0, 0, 0), 1, zero);
        add_row(obs(KIND_APPLY, 1, 1, 7, 1, 200, CLS_OPEN, FIT_NONE, 0, 0, 0, 0), 1, zero);
        add_row(obs(KIND_APPLY, 1, 1, DIR_UP, 1, 200, CLS_AMBIG, FIT_NONE, 0, 0, 0, 0), 1, zero);
        add_row(obs(KIND_APPLY, 1, 1, DIR_UP, 1, 200, CLS_POST, FIT_NONE, 0, 0, 0, 0), 1, zero);
        add_row(obs(KIND_APPLY, 1, 1, DIR_UP, 1, 200, CLS_OPEN, FIT_POST, 0, 0, 0, 0), 1, zero);
        add_row(obs(KIND_APPLY, 0, 0, DIR_UP, 1, 128, CLS_WALL, FIT_NONE, 0, 0, 0, 0), 1,
                res(1'b1, 8'sd2, EDGE_UNKNOWN));
        add_row(obs(KIND_APPLY, 0, 1, DIR_DOWN, 1, 255, CLS_WALL, FIT_NONE, 0, 0, 0, 0), 1,
                res(1'b1, 8'sd4, EDGE_WALL));
        add_row(obs(KIND_QUERY, 0, 0, DIR_UP, 0, 0, CLS_WALL, FIT_NONE, 0, 0, 0, 0), 1,
                res(1'b0, 8'sd4, EDGE_WALL));
        add_row(obs(KIND_APPLY, 15, 15, DIR_RIGHT, 1, 255, CLS_OPEN, FIT_OTHER, 3, 3, 0, 0), 1,
                res(1'b1, -8'sd1, EDGE_UNKNOWN));
        add_row(obs(KIND_QUERY, 15, 15, 4, 0, 0, CLS_WALL, FIT_NONE, 0, 0, 0, 0), 1,
                res(1'b0, -8'sd1, EDGE_UNKNOWN));
        add_row(obs(KIND_APPLY, 3, 3, DIR_UP, 1, 200, CLS_OPEN, FIT_FACE, 15, 15, DIR_RIGHT, 0),
                0, dummy);
        add_row(obs(KIND_APPLY, 3, 3, DIR_LEFT, 1, 200, CLS_WALL, FIT_FACE, 9, 9, 7, 0), 0, dummy);
        add_row(obs(KIND_APPLY, 15, 0, DIR_LEFT, 1, 200, CLS_WALL, FIT_POST, 2, 2, 1, 0), 0,
                dummy);
        add_row(obs(KIND_APPLY, 0, 15, DIR_UP, 1, 255, CLS_WALL, FIT_NONE, 15, 15, 7, 0), 0,
                dummy);
        add_row(obs(KIND_APPLY, 3, 3, DIR_DOWN, 1, 255, CLS_OPEN, FIT_FACE, 2, 2, DIR_UP, 0), 0,
                dummy);
        add_row(obs(KIND_QUERY, 15, 15, DIR_RIGHT, 1, 255, CLS_POST, FIT_OTHER, 15, 15, 7, 1),
                0, dummy);
        add_row(obs(KIND_QUERY, 3, 3, DIR_LEFT, 0, 0, CLS_WALL, FIT_NONE, 0, 0, 0, 0), 0, dummy);
        add_row(obs(KIND_APPLY, 15, 15, DIR_RIGHT, 1, 255, CLS_OPEN, FIT_OTHER, 15, 15, 7, 1), 1,
                zero);

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].it, directed_rows[i].fixed, directed_rows[i].want);
        end
        stop_and_drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: apply_cfg(0, 127, 127, 127, 127, 127);
                1: apply_cfg(255, 1, 1, 1, -127, -127);
                2: apply_cfg(128, 0, 0, 0, 0, 0);
                3: apply_cfg(100, 3, 2, 10, 4, 4);
                default: apply_cfg($urandom_range(0, 255), $urandom_range(0, 127),
                                   $urandom_range(0, 127), $urandom_range(0, 127),
                                   $urandom_range(0, 255), $urandom_range(0, 255));
            endcase
            no_gaps = phase[0];
            n = 0;
            while (n < 100) begin
                send_word(random_obs(), 1'b0, dummy);
                n++;
                if ($urandom_range(0, 59) == 0) begin
                    stop_and_drain();
                end
            end
            stop_and_drain();
        end

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
